// ===== src/ppp_pkg.sv =====
// Shared widths and constants for the point projection unit.
package ppp_pkg;
	// transformed coordinate width: three 64-bit products summed, plus offset
	localparam int unsigned TW = 66;
	localparam int unsigned NCOEF = 16;
	localparam int unsigned IDX_W = 4;
	localparam int unsigned QW = 32;
	localparam logic [QW-1:0] POS_LIM = 32'h7FFF_FFFF;
	localparam logic [QW-1:0] NEG_LIM = 32'h8000_0000;
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_POINT = 1'b1;
	localparam int unsigned XFORM_LAT = 3;
	localparam int unsigned DIV_LAT = QW + 3;
endpackage

// ===== src/ppp_transform.sv =====
// Coefficient store and three-stage matrix-vector product with zero-w clamp.
module ppp_transform #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          load,
	input  logic [ppp_pkg::IDX_W-1:0]     coef_index,
	input  logic signed [31:0]            coef_value,
	input  logic signed [31:0]            pos_x,
	input  logic signed [31:0]            pos_y,
	input  logic signed [31:0]            pos_z,
	output logic signed [ppp_pkg::TW-1:0] tx_s3,
	output logic signed [ppp_pkg::TW-1:0] ty_s3,
	output logic signed [ppp_pkg::TW-1:0] tw_s3,
	output logic                          clamp_s3
);
	localparam int unsigned TW = ppp_pkg::TW;
	localparam logic [31:0] ONE = 32'(64'd1 << FRAC_BITS);

	logic signed [31:0] mat_q [ppp_pkg::NCOEF];
	logic signed [63:0] prod_s1 [3][3];
	logic signed [31:0] off_s1 [3];
	logic signed [TW-1:0] sum_s2 [3];
	logic signed [TW-1:0] sum_c [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ppp_pkg::NCOEF; i++) begin
				mat_q[i] <= (i % 5 == 0) ? ONE : 32'sd0;
			end
		end else if (load) begin
			mat_q[coef_index] <= coef_value;
		end
	end

	// rows used: x (0), y (1), w (3)
	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				prod_s1[r][0] <= mat_q[(r == 2) ? 3 : r] * pos_x;
				prod_s1[r][1] <= mat_q[4 + ((r == 2) ? 3 : r)] * pos_y;
				prod_s1[r][2] <= mat_q[8 + ((r == 2) ? 3 : r)] * pos_z;
				off_s1[r] <= mat_q[12 + ((r == 2) ? 3 : r)];
			end
		end
	end

	// floor of the exact sum equals the sum of floors plus carried remainders
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			sum_c[r] = (TW'(prod_s1[r][0]) + TW'(prod_s1[r][1]) + TW'(prod_s1[r][2]))
				>>> FRAC_BITS;
			sum_c[r] = sum_c[r] + TW'(off_s1[r]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) sum_s2[r] <= sum_c[r];
			tx_s3 <= sum_s2[0];
			ty_s3 <= sum_s2[1];
			clamp_s3 <= (sum_s2[2] == '0);
			tw_s3 <= (sum_s2[2] == '0) ? TW'(1) : sum_s2[2];
		end
	end
endmodule

// ===== src/ppp_div.sv =====
// Pipelined restoring divider: (num << FRAC_BITS) / den, truncated and saturated.
module ppp_div #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [ppp_pkg::TW-1:0] num,
	input  logic signed [ppp_pkg::TW-1:0] den,
	output logic signed [31:0]            quo
);
	localparam int unsigned TW = ppp_pkg::TW;
	localparam int unsigned QW = ppp_pkg::QW;
	localparam int unsigned SW = TW + FRAC_BITS;

	logic [TW-1:0] n_q, d0_q;
	logic          neg0_q;
	logic [SW-1:0] nsh;

	logic [TW-1:0] r_q [QW+1];
	logic [TW-1:0] d_q [QW+1];
	logic [QW-1:0] lo_q [QW+1];
	logic [QW-1:0] q_q [QW+1];
	logic          neg_q [QW+1];
	logic          sat_q [QW+1];

	// take magnitudes
	always_ff @(posedge clk) begin
		if (en) begin
			n_q <= num[TW-1] ? TW'(-num) : TW'(num);
			d0_q <= den[TW-1] ? TW'(-den) : TW'(den);
			neg0_q <= num[TW-1] ^ den[TW-1];
		end
	end

	assign nsh = {n_q, FRAC_BITS'(0)};

	// the high part at or above the divisor means the quotient overflows 32 bits
	always_ff @(posedge clk) begin
		if (en) begin
			r_q[0] <= TW'(nsh[SW-1:QW]);
			lo_q[0] <= nsh[QW-1:0];
			d_q[0] <= d0_q;
			q_q[0] <= '0;
			neg_q[0] <= neg0_q;
			sat_q[0] <= (TW'(nsh[SW-1:QW]) >= d0_q);
		end
	end

	for (genvar k = 0; k < QW; k++) begin : g_iter
		logic [TW:0] t;
		logic        ge;
		assign t = {r_q[k], lo_q[k][QW-1]};
		assign ge = (t >= {1'b0, d_q[k]});
		always_ff @(posedge clk) begin
			if (en) begin
				r_q[k+1] <= ge ? TW'(t - {1'b0, d_q[k]}) : TW'(t);
				lo_q[k+1] <= {lo_q[k][QW-2:0], 1'b0};
				q_q[k+1] <= {q_q[k][QW-2:0], ge};
				d_q[k+1] <= d_q[k];
				neg_q[k+1] <= neg_q[k];
				sat_q[k+1] <= sat_q[k];
			end
		end
	end

	logic [QW-1:0] lim, qm;
	always_comb begin
		lim = neg_q[QW] ? ppp_pkg::NEG_LIM : ppp_pkg::POS_LIM;
		qm = (sat_q[QW] || q_q[QW] > lim) ? lim : q_q[QW];
	end

	always_ff @(posedge clk) begin
		if (en) quo <= neg_q[QW] ? -qm : qm;
	end
endmodule

// ===== src/point_project_perspective_unit.sv =====
// Projection unit: a 4x4 Q-format transform of (x, y, z, 1) with divide by w.
// A point request yields one result. One request may be accepted every cycle
// while the output is not stalled. The pipeline has three transform stages (multiply,
// sum, w clamp) and a 35-stage divider: magnitudes, alignment with the overflow
// test, one stage per quotient bit for 32 bits, and the final sign and saturation.
// Load requests write a coefficient at acceptance, give no result, and apply to
// every point accepted later. The pipeline holds as a whole while a result waits.
module point_project_perspective_unit #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      op,
	input  logic [3:0]                coef_index,
	input  logic signed [31:0]        coef_value,
	input  logic signed [31:0]        pos_x,
	input  logic signed [31:0]        pos_y,
	input  logic signed [31:0]        pos_z,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [31:0]        proj_x,
	output logic signed [31:0]        proj_y,
	output logic                      w_clamped
);
	localparam int unsigned LAT = ppp_pkg::XFORM_LAT + ppp_pkg::DIV_LAT;
	localparam int unsigned TW = ppp_pkg::TW;

	logic en, acc;
	logic signed [TW-1:0] tx_s3, ty_s3, tw_s3;
	logic clamp_s3;
	logic [LAT-1:0] vld_q;
	logic [ppp_pkg::DIV_LAT-1:0] clamp_q;

	assign en = !out_valid || out_ready;
	assign in_ready = en;
	assign acc = in_valid && in_ready;

	ppp_transform #(.FRAC_BITS(FRAC_BITS)) u_xform (
		.clk, .arst_n, .en,
		.load(acc && op == ppp_pkg::OP_LOAD),
		.coef_index, .coef_value, .pos_x, .pos_y, .pos_z,
		.tx_s3, .ty_s3, .tw_s3, .clamp_s3
	);

	ppp_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
		.clk, .en, .num(tx_s3), .den(tw_s3), .quo(proj_x)
	);

	ppp_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
		.clk, .en, .num(ty_s3), .den(tw_s3), .quo(proj_y)
	);

	// advance valid bits alongside the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], acc && op == ppp_pkg::OP_POINT};
		end
	end

	always_ff @(posedge clk) begin
		if (en) clamp_q <= {clamp_q[ppp_pkg::DIV_LAT-2:0], clamp_s3};
	end

	assign out_valid = vld_q[LAT-1];
	assign w_clamped = clamp_q[ppp_pkg::DIV_LAT-1];
endmodule
